/* rtl/sam_pkg.sv */
// sam_pkg: shared types and constants for the suffix automaton core.
// Used by sam_ctrl, sam_dpath and the top level; depends on nothing.
package sam_pkg;

  localparam int SYM_W = 5;
  localparam int OUT_W = 13;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECIDE, S_CLR, S_BCHK, S_SETUP, S_NEW, S_WALK,
    S_LROOT, S_NXT, S_LCUR, S_LNXT, S_REDIR, S_MSTART, S_MCHK, S_MBAD,
    S_OUT, S_OUTFULL
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ROOT, OP_SETUP, OP_NEW, OP_WALK, OP_LROOT, OP_NXT,
    OP_LCUR, OP_LNXT, OP_REDIR, OP_MSTART, OP_MCHK, OP_MBAD, OP_OUT,
    OP_OUTFULL
  } op_t;

  typedef enum logic [2:0] {
    RD_WALK, RD_LAST, RD_LINK, RD_HIT, RD_MSTART
  } rd_sel_t;

  typedef struct packed {
    op_t     op;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic sym_bad;
    logic full;
    logic hit;
    logic link_zero;
    logic len_ok;
    logic eq_nxt;
    logic out_free;
  } status_t;

endpackage

/* rtl/sam_ram.sv */
// sam_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module sam_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/sam_ctrl.sv */
// sam_ctrl: sequencer for build and match steps of the suffix automaton.
// Depends on sam_pkg.
module sam_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              mode,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              load,
  input  sam_pkg::status_t  st,
  output sam_pkg::cmd_t     cmd
);
  sam_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sam_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sam_pkg::S_INIT:   state_next = sam_pkg::S_IDLE;
      sam_pkg::S_IDLE:   if (s_tvalid) state_next = sam_pkg::S_DECIDE;
      sam_pkg::S_DECIDE: begin
        if (!mode) state_next = st.first ? sam_pkg::S_CLR : sam_pkg::S_BCHK;
        else       state_next = st.sym_bad ? sam_pkg::S_MBAD : sam_pkg::S_MSTART;
      end
      sam_pkg::S_CLR:    state_next = sam_pkg::S_BCHK;
      sam_pkg::S_BCHK: begin
        priority if (st.sym_bad) state_next = sam_pkg::S_OUT;
        else if (st.full)       state_next = sam_pkg::S_OUTFULL;
        else                    state_next = sam_pkg::S_SETUP;
      end
      sam_pkg::S_SETUP:  state_next = sam_pkg::S_NEW;
      sam_pkg::S_NEW:    state_next = sam_pkg::S_WALK;
      sam_pkg::S_WALK: begin
        if (st.hit)            state_next = sam_pkg::S_NXT;
        else if (st.link_zero) state_next = sam_pkg::S_LROOT;
      end
      sam_pkg::S_LROOT:  state_next = sam_pkg::S_OUT;
      sam_pkg::S_NXT:    state_next = st.len_ok ? sam_pkg::S_OUT : sam_pkg::S_LCUR;
      sam_pkg::S_LCUR:   state_next = sam_pkg::S_LNXT;
      sam_pkg::S_LNXT:   state_next = sam_pkg::S_REDIR;
      sam_pkg::S_REDIR:  if (!st.eq_nxt || st.link_zero) state_next = sam_pkg::S_OUT;
      sam_pkg::S_MSTART: state_next = sam_pkg::S_MCHK;
      sam_pkg::S_MCHK:   if (st.hit || st.link_zero) state_next = sam_pkg::S_OUT;
      sam_pkg::S_MBAD:   state_next = sam_pkg::S_OUT;
      sam_pkg::S_OUT, sam_pkg::S_OUTFULL: if (st.out_free) state_next = sam_pkg::S_IDLE;
      default:           state_next = sam_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd.op     = sam_pkg::OP_NONE;
    cmd.rd_sel = sam_pkg::RD_WALK;
    s_tready   = 1'b0;
    unique case (state)
      sam_pkg::S_INIT, sam_pkg::S_CLR: cmd.op = sam_pkg::OP_ROOT;
      sam_pkg::S_IDLE:   s_tready = 1'b1;
      sam_pkg::S_SETUP: begin
        cmd.op = sam_pkg::OP_SETUP;
        cmd.rd_sel = sam_pkg::RD_LAST;
      end
      sam_pkg::S_NEW: begin
        cmd.op = sam_pkg::OP_NEW;
        cmd.rd_sel = sam_pkg::RD_LAST;
      end
      sam_pkg::S_WALK: begin
        cmd.op = sam_pkg::OP_WALK;
        cmd.rd_sel = st.hit ? sam_pkg::RD_HIT : sam_pkg::RD_LINK;
      end
      sam_pkg::S_LROOT:  cmd.op = sam_pkg::OP_LROOT;
      sam_pkg::S_NXT:    cmd.op = sam_pkg::OP_NXT;
      sam_pkg::S_LCUR:   cmd.op = sam_pkg::OP_LCUR;
      sam_pkg::S_LNXT:   cmd.op = sam_pkg::OP_LNXT;
      sam_pkg::S_REDIR: begin
        cmd.op = sam_pkg::OP_REDIR;
        cmd.rd_sel = sam_pkg::RD_LINK;
      end
      sam_pkg::S_MSTART: begin
        cmd.op = sam_pkg::OP_MSTART;
        cmd.rd_sel = sam_pkg::RD_MSTART;
      end
      sam_pkg::S_MCHK: begin
        cmd.op = sam_pkg::OP_MCHK;
        cmd.rd_sel = sam_pkg::RD_LINK;
      end
      sam_pkg::S_MBAD:   cmd.op = sam_pkg::OP_MBAD;
      sam_pkg::S_OUT:    if (st.out_free) cmd.op = sam_pkg::OP_OUT;
      sam_pkg::S_OUTFULL: if (st.out_free) cmd.op = sam_pkg::OP_OUTFULL;
      default:           cmd.op = sam_pkg::OP_NONE;
    endcase
  end

  assign load = s_tvalid && s_tready;
endmodule

/* rtl/sam_dpath.sv */
// sam_dpath: state tables, walk registers and result register of the automaton.
// Depends on sam_pkg and sam_ram.
module sam_dpath #(
  parameter int SLOTS    = 8192,
  parameter int ALPHABET = 26
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        mode,
  input  logic                        load,
  input  logic [sam_pkg::SYM_W-1:0]   in_sym,
  input  logic                        in_first,
  input  sam_pkg::cmd_t               cmd,
  output sam_pkg::status_t            st,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [sam_pkg::OUT_W-1:0]   match_len,
  output logic [sam_pkg::OUT_W-1:0]   state_count,
  output logic                        full_res
);
  localparam int SW = $clog2(SLOTS);
  localparam int RW = ALPHABET * SW;
  localparam logic [SW-1:0] ROOT = SW'(1);

  logic [sam_pkg::SYM_W-1:0] c_q;
  logic first_q;
  logic [SW-1:0] walk, cur, nxt, twin, used, last, lenw, mstate, mlen, plen;
  logic walked;
  logic [SW-1:0] rd_addr, rd_addr_q;
  logic [SW-1:0] used_inc;

  logic [RW-1:0] trans_rd, row_v, row_mod, trans_wd;
  logic [SW-1:0] link_rd, link_v, len_rd, len_v, link_wd, len_wd;
  logic [SW-1:0] trans_wa, link_wa, len_wa;
  logic trans_we, link_we, len_we, rd_ok;
  logic [SW-1:0] hit_val, wr_val, lc;
  logic [ALPHABET-1:0][SW-1:0] hit_parts;

  assign used_inc = used + ROOT;

  always_comb begin
    unique case (cmd.rd_sel)
      sam_pkg::RD_WALK:   rd_addr = walk;
      sam_pkg::RD_LAST:   rd_addr = last;
      sam_pkg::RD_LINK:   rd_addr = link_v;
      sam_pkg::RD_HIT:    rd_addr = hit_val;
      sam_pkg::RD_MSTART: rd_addr = first_q ? ROOT : mstate;
      default:            rd_addr = walk;
    endcase
  end

  // slots above the fill count (or slot zero) read as never written
  assign rd_ok  = (rd_addr_q != '0) && (rd_addr_q <= used);
  assign row_v  = rd_ok ? trans_rd : '0;
  assign link_v = rd_ok ? link_rd : '0;
  assign len_v  = rd_ok ? len_rd : '0;
  assign wr_val = (cmd.op == sam_pkg::OP_REDIR) ? twin : cur;

  for (genvar k = 0; k < ALPHABET; k++) begin : g_lane
    logic sel;
    assign sel = (int'(c_q) == k);
    assign hit_parts[k] = sel ? row_v[k*SW +: SW] : '0;
    assign row_mod[k*SW +: SW] = sel ? wr_val : row_v[k*SW +: SW];
  end

  always_comb begin
    hit_val = '0;
    for (int k = 0; k < ALPHABET; k++) begin
      hit_val = hit_val | hit_parts[k];
    end
  end

  assign lc = walked ? len_v : plen;

  assign st.first     = first_q;
  assign st.sym_bad   = int'(c_q) >= ALPHABET;
  assign st.full      = ({1'b0, used} + (SW+1)'(2)) > (SW+1)'(SLOTS - 1);
  assign st.hit       = hit_val != '0;
  assign st.link_zero = link_v == '0;
  assign st.len_ok    = len_v == lenw + ROOT;
  assign st.eq_nxt    = hit_val == nxt;
  assign st.out_free  = !m_tvalid || m_tready;

  always_comb begin
    trans_we = 1'b0; trans_wa = walk; trans_wd = row_mod;
    link_we  = 1'b0; link_wa  = cur;  link_wd  = '0;
    len_we   = 1'b0; len_wa   = cur;  len_wd   = '0;
    unique case (cmd.op)
      sam_pkg::OP_ROOT: begin
        trans_we = 1'b1; trans_wa = ROOT; trans_wd = '0;
        link_we = 1'b1; link_wa = ROOT;
        len_we = 1'b1; len_wa = ROOT;
      end
      sam_pkg::OP_NEW: begin
        trans_we = 1'b1; trans_wa = used_inc; trans_wd = '0;
        link_we = 1'b1; link_wa = used_inc;
        len_we = 1'b1; len_wa = used_inc; len_wd = len_v + ROOT;
      end
      sam_pkg::OP_WALK:  trans_we = !st.hit;
      sam_pkg::OP_LROOT: begin
        link_we = 1'b1; link_wd = ROOT;
      end
      sam_pkg::OP_NXT: begin
        if (st.len_ok) begin
          link_we = 1'b1; link_wd = nxt;
        end else begin
          // clone nxt into a fresh slot with the shorter length
          trans_we = 1'b1; trans_wa = used_inc; trans_wd = row_v;
          link_we = 1'b1; link_wa = used_inc; link_wd = link_v;
          len_we = 1'b1; len_wa = used_inc; len_wd = lenw + ROOT;
        end
      end
      sam_pkg::OP_LCUR: begin
        link_we = 1'b1; link_wd = twin;
      end
      sam_pkg::OP_LNXT: begin
        link_we = 1'b1; link_wa = nxt; link_wd = twin;
      end
      sam_pkg::OP_REDIR: trans_we = st.eq_nxt;
      default: ;
    endcase
  end

  sam_ram #(.W(RW), .D(SLOTS)) u_trans (
    .clk(clk), .we(trans_we), .waddr(trans_wa), .wdata(trans_wd),
    .raddr(rd_addr), .rdata(trans_rd)
  );
  sam_ram #(.W(SW), .D(SLOTS)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(rd_addr), .rdata(link_rd)
  );
  sam_ram #(.W(SW), .D(SLOTS)) u_len (
    .clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd),
    .raddr(rd_addr), .rdata(len_rd)
  );

  // payload registers
  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    if (load) begin
      c_q <= in_sym;
      first_q <= in_first;
    end
    unique case (cmd.op)
      sam_pkg::OP_SETUP: walk <= last;
      sam_pkg::OP_NEW:   cur <= used_inc;
      sam_pkg::OP_WALK: begin
        if (!st.hit) begin
          walk <= link_v;
        end else begin
          nxt <= hit_val;
          lenw <= len_v;
        end
      end
      sam_pkg::OP_NXT:   if (!st.len_ok) twin <= used_inc;
      sam_pkg::OP_REDIR: if (st.eq_nxt) walk <= link_v;
      sam_pkg::OP_MSTART: begin
        walk <= first_q ? ROOT : mstate;
        plen <= first_q ? '0 : mlen;
      end
      sam_pkg::OP_MCHK:  if (!st.hit && !st.link_zero) walk <= link_v;
      sam_pkg::OP_OUT, sam_pkg::OP_OUTFULL: begin
        match_len   <= mode ? sam_pkg::OUT_W'(mlen) : '0;
        state_count <= sam_pkg::OUT_W'(used);
        full_res    <= (cmd.op == sam_pkg::OP_OUTFULL);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= ROOT;
      last <= ROOT;
      mstate <= ROOT;
      mlen <= '0;
      walked <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      unique case (cmd.op)
        sam_pkg::OP_ROOT: begin
          used <= ROOT;
          last <= ROOT;
        end
        sam_pkg::OP_NEW: begin
          used <= used_inc;
          last <= used_inc;
        end
        sam_pkg::OP_NXT:    if (!st.len_ok) used <= used_inc;
        sam_pkg::OP_MSTART: walked <= 1'b0;
        sam_pkg::OP_MCHK: begin
          if (st.hit) begin
            mstate <= hit_val;
            mlen <= lc + ROOT;
          end else if (st.link_zero) begin
            mstate <= ROOT;
            mlen <= '0;
          end else begin
            walked <= 1'b1;
          end
        end
        sam_pkg::OP_MBAD: begin
          mstate <= ROOT;
          mlen <= '0;
        end
        sam_pkg::OP_OUT, sam_pkg::OP_OUTFULL: m_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

/* rtl/suffix_automaton_build_and_match_core.sv */
// suffix_automaton_build_and_match_core: top level, APB mode register, stream ports.
// Depends on sam_pkg, sam_ctrl, sam_dpath (and sam_ram through it).
//
// channel  | direction | handshake          | contents
// s_*      | in        | s_tvalid/s_tready  | tdata[4:0] symbol, tlast = first
// m_*      | out       | m_tvalid/m_tready  | tdata[12:0] match_len, [25:13] state_count;
//          |           |                    | tuser = full_res
// apb      | in        | psel/penable       | reg 0 at 0x0: mode (0 build, 1 match)
//
// One item is in flight at a time; the next is taken once the result is in the
// output register. A build step walks suffix links one at a time, adds a CLR step
// when the start flag clears the table and the LCUR, LNXT and REDIR steps (REDIR
// once per redirected link) when a state is cloned; an out-of-range letter or a
// full table goes straight to output. A match step follows suffix links one at a
// time until a hit or a zero link. The walk is bounded by the single read port of
// the state tables. After reset the INIT state clears the root row before the
// first transfer is accepted. A stalled output holds the core in its output state.
module suffix_automaton_build_and_match_core #(
  parameter int MAX_CHARS = 4096,
  parameter int ALPHABET  = 26
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] symbol
  input  logic        s_tlast,   // first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [12:0] match_len, [25:13] state_count
  output logic        m_tuser,   // full_res
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int SLOTS = 2 * MAX_CHARS;

  logic mode;
  logic load;
  sam_pkg::cmd_t    cmd;
  sam_pkg::status_t st;
  logic [sam_pkg::OUT_W-1:0] match_len, state_count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      mode <= pwdata[0];
    end
  end

  sam_ctrl u_ctrl (
    .clk(clk), .rst(rst), .mode(mode), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .load(load), .st(st), .cmd(cmd)
  );

  sam_dpath #(.SLOTS(SLOTS), .ALPHABET(ALPHABET)) u_dpath (
    .clk(clk), .rst(rst), .mode(mode), .load(load),
    .in_sym(s_tdata[sam_pkg::SYM_W-1:0]), .in_first(s_tlast),
    .cmd(cmd), .st(st), .m_tready(m_tready), .m_tvalid(m_tvalid),
    .match_len(match_len), .state_count(state_count), .full_res(m_tuser)
  );

  assign m_tdata = {6'b0, state_count, match_len};

  // one item at a time: a transfer in is never followed by another next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken twice in a row");

  // a full table only happens in build mode, where match_len is zero
  a_full_no_match: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[12:0] == 13'd0))
    else $error("full flag with nonzero match length");

  // the root row is cleared before the first input is taken
  a_init_gap: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input ready during root clear");
endmodule
